// File: hw/rtl/jecm_pkg.sv
// ---------------------------------------------------------------------------
// jecm_pkg: shared constants and tables of the joystick curve map
// widths, register codes and the exponential lookup tables
// ---------------------------------------------------------------------------
package jecm_pkg;

    localparam int ADC_BITS_DEF   = 12;
    localparam int FULL_SCALE_DEF = 1000;

    localparam int SLOPE_W = 12;   // q4.8 signed slopes
    localparam int OUT_W   = 11;   // result word width
    localparam int QUO_W   = 16;   // quotient bits kept by each divider
    localparam int FS_W    = 16;   // full scale magnitude bits
    localparam int MULT_W  = 17;   // signed multiplier operand of the first divide
    localparam int X_W     = QUO_W + 2;
    localparam int PTAB_W  = 38;
    localparam int FTAB_W  = 26;
    localparam int EXP_W   = PTAB_W + FTAB_W - 24;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 12'sd1280;

    // pipeline depth from start to result strobe
    localparam int LATENCY = 2 * QUO_W + 14;

    localparam logic [2:0] REG_CAL_MIN     = 3'd0;
    localparam logic [2:0] REG_CAL_CENTRE  = 3'd1;
    localparam logic [2:0] REG_CAL_MAX     = 3'd2;
    localparam logic [2:0] REG_SLOPE_START = 3'd3;
    localparam logic [2:0] REG_SLOPE_END   = 3'd4;

    localparam logic [63:0] EQ24 = 64'd45605201;
    localparam logic [63:0] SQ24 = 64'd16842880;

    typedef logic [PTAB_W-1:0] t_ptab [16];
    typedef logic [FTAB_W-1:0] t_ftab [256];

    // integer part: 65536 * e^k, truncated at each step
    function automatic t_ptab build_ptab();
        t_ptab       t;
        logic [63:0] p;
        p = 64'd65536;
        for (int i = 0; i < 16; i++) begin
            t[i] = PTAB_W'(p);
            p    = (p * EQ24) >> 24;
        end
        return t;
    endfunction

    // fraction part: 2^24 * e^(f/256), truncated at each step
    function automatic t_ftab build_ftab();
        t_ftab       t;
        logic [63:0] q;
        q = 64'd16777216;
        for (int i = 0; i < 256; i++) begin
            t[i] = FTAB_W'(q);
            q    = (q * SQ24) >> 24;
        end
        return t;
    endfunction

    localparam t_ptab PTAB = build_ptab();
    localparam t_ftab FTAB = build_ftab();

endpackage

// File: hw/rtl/joystick_expo_curve_map_top.sv
// ---------------------------------------------------------------------------
// joystick_expo_curve_map_top: one-axis joystick exponential curve map
// clamp, half select, exponential shaping and saturation of an adc word
// ---------------------------------------------------------------------------
// the block takes one adc word per clock whenever start is high (busy never
// rises) and delivers each result word in order as a one-cycle o_strobe
// pulse; the receiver cannot stall, so it must take every strobed word. the
// path runs through two 16-step pipelined dividers (position within the
// half, then the curve ratio), the three-stage exponential lookup and the
// surrounding register stages. the user is to write calibration and slopes
// over the apb-style port while no word is in flight; this is not enforced.
module joystick_expo_curve_map_top #(
    parameter int ADC_BITS       = jecm_pkg::ADC_BITS_DEF,
    parameter int OUT_FULL_SCALE = jecm_pkg::FULL_SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ADC_BITS-1:0]                 i_sample,
    output logic                                o_strobe,
    output logic signed [jecm_pkg::OUT_W-1:0]   o_axis_value,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jecm_pkg::ADDR_W-1:0]         paddr,
    input  logic [jecm_pkg::DATA_W-1:0]         pwdata,
    output logic [jecm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int AW   = ADC_BITS;
    localparam int DVW  = AW + 1;
    localparam int MW   = jecm_pkg::MULT_W;
    localparam int SLW  = jecm_pkg::SLOPE_W;
    localparam int FSW  = jecm_pkg::FS_W;
    localparam int QW   = jecm_pkg::QUO_W;
    localparam int XW   = jecm_pkg::X_W;
    localparam int EW   = jecm_pkg::EXP_W;
    localparam int OW   = jecm_pkg::OUT_W;
    localparam int PW1  = DVW + MW - 1;
    localparam int NW2  = EW + FSW;
    localparam logic [FSW-1:0] FS = FSW'(OUT_FULL_SCALE);
    localparam logic [AW-1:0]  CENTRE_RESET = AW'((1 << (AW - 1)) - 1);

    typedef struct packed {
        logic                  sgn;
        logic                  lin;
        logic                  zspan;
        logic                  lower;
        logic signed [SLW-1:0] s;
        logic signed [SLW-1:0] e;
    } t_s1;

    typedef struct packed {
        logic                  lin;
        logic                  zspan;
        logic                  lower;
        logic                  dz;
        logic                  neg;
        logic signed [FSW:0]   lres;
    } t_s2;

    // ---------------- configuration registers ----------------
    logic [AW-1:0]          r_cal_min, r_cal_centre, r_cal_max;
    logic signed [SLW-1:0]  r_slope_start, r_slope_end;
    logic                   cfg_wr;
    logic [2:0]             cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;   // every stage moves each cycle
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[jecm_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min     <= '0;
            r_cal_centre  <= CENTRE_RESET;
            r_cal_max     <= '1;
            r_slope_start <= jecm_pkg::SLOPE_RESET;
            r_slope_end   <= jecm_pkg::SLOPE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                jecm_pkg::REG_CAL_MIN:     r_cal_min     <= pwdata[AW-1:0];
                jecm_pkg::REG_CAL_CENTRE:  r_cal_centre  <= pwdata[AW-1:0];
                jecm_pkg::REG_CAL_MAX:     r_cal_max     <= pwdata[AW-1:0];
                jecm_pkg::REG_SLOPE_START: r_slope_start <= pwdata[SLW-1:0];
                jecm_pkg::REG_SLOPE_END:   r_slope_end   <= pwdata[SLW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            jecm_pkg::REG_CAL_MIN:     prdata = jecm_pkg::DATA_W'(r_cal_min);
            jecm_pkg::REG_CAL_CENTRE:  prdata = jecm_pkg::DATA_W'(r_cal_centre);
            jecm_pkg::REG_CAL_MAX:     prdata = jecm_pkg::DATA_W'(r_cal_max);
            jecm_pkg::REG_SLOPE_START: prdata = jecm_pkg::DATA_W'(unsigned'(r_slope_start));
            jecm_pkg::REG_SLOPE_END:   prdata = jecm_pkg::DATA_W'(unsigned'(r_slope_end));
            default:                   prdata = '0;
        endcase
    end

    // ---------------- stage a: clamp to calibrated range ----------------
    // minimum is tested first so an inverted calibration still resolves
    logic          r_a_vld;
    logic [AW-1:0] r_a_v, n_a_v;

    always_comb begin
        if (i_sample < r_cal_min) begin
            n_a_v = r_cal_min;
        end else if (i_sample > r_cal_max) begin
            n_a_v = r_cal_max;
        end else begin
            n_a_v = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_v <= n_a_v;
    end

    // ---------------- stage b: half select, offsets ----------------
    logic                   r_b_vld;
    logic signed [DVW-1:0]  r_b_dv, r_b_span;
    logic signed [MW-1:0]   r_b_mult;
    logic                   r_b_lin, r_b_zspan, r_b_lower;
    logic signed [SLW-1:0]  r_b_s, r_b_e;
    logic                   b_upper, b_lin;
    logic [AW-1:0]          b_end;

    assign b_upper = r_a_v >= r_cal_centre;
    assign b_end   = b_upper ? r_cal_max : r_cal_min;
    assign b_lin   = r_slope_start == r_slope_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_dv    <= signed'({1'b0, r_a_v}) - signed'({1'b0, r_cal_centre});
        r_b_span  <= signed'({1'b0, b_end}) - signed'({1'b0, r_cal_centre});
        r_b_zspan <= b_end == r_cal_centre;
        r_b_lower <= !b_upper;
        r_b_lin   <= b_lin;
        // linear map multiplies by full scale, curve map by the slope span
        r_b_mult  <= b_lin ? signed'(MW'(FS))
                           : MW'(r_slope_end) - MW'(r_slope_start);
        r_b_s     <= r_slope_start;
        r_b_e     <= r_slope_end;
    end

    // ---------------- stage c: magnitudes and signs ----------------
    logic             r_c_vld;
    logic [DVW-1:0]   r_c_dvm, r_c_spm;
    logic [MW-2:0]    r_c_mm;
    t_s1              r_c_sd;
    logic [MW-1:0]    c_mabs;

    assign c_mabs = r_b_mult[MW-1] ? MW'(-r_b_mult) : MW'(r_b_mult);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_dvm      <= r_b_dv[DVW-1] ? DVW'(-r_b_dv) : DVW'(r_b_dv);
        r_c_spm      <= r_b_span[DVW-1] ? DVW'(-r_b_span) : DVW'(r_b_span);
        r_c_mm       <= c_mabs[MW-2:0];
        r_c_sd.sgn   <= r_b_dv[DVW-1] ^ r_b_mult[MW-1] ^ r_b_span[DVW-1];
        r_c_sd.lin   <= r_b_lin;
        r_c_sd.zspan <= r_b_zspan;
        r_c_sd.lower <= r_b_lower;
        r_c_sd.s     <= r_b_s;
        r_c_sd.e     <= r_b_e;
    end

    // ---------------- stage d: numerator product ----------------
    logic             r_d_vld;
    logic [PW1-1:0]   r_d_prod;
    logic [DVW-1:0]   r_d_spm;
    t_s1              r_d_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_prod <= PW1'(r_c_dvm) * PW1'(r_c_mm);
        r_d_spm  <= r_c_spm;
        r_d_sd   <= r_c_sd;
    end

    // ---------------- first divide: position within the half ----------------
    logic          d1_vld;
    logic [QW-1:0] d1_quo;
    t_s1           d1_sd;

    jecm_div #(.NW(PW1), .DW(DVW), .SW($bits(t_s1))) u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_vld),
        .i_num   (r_d_prod),
        .i_den   (r_d_spm),
        .i_side  (r_d_sd),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_sd)
    );

    // ---------------- stage e: linear result and curve exponent ----------------
    logic                  r_e_vld;
    logic signed [SLW-1:0] r_e_x [3];
    t_s2                   r_e_sd;
    logic [FSW-1:0]        e_lm;
    logic signed [XW-1:0]  e_s, e_q, e_xs;
    logic signed [SLW-1:0] e_x;

    assign e_lm = (d1_quo > QW'(FS)) ? FS : FSW'(d1_quo);
    assign e_s  = XW'(d1_sd.s);
    assign e_q  = signed'(XW'(d1_quo));
    assign e_xs = d1_sd.sgn ? e_s - e_q : e_s + e_q;

    // exponent clamped to the q4.8 range
    always_comb begin
        if (e_xs < -(XW'(1) <<< (SLW - 1))) begin
            e_x = {1'b1, {(SLW-1){1'b0}}};
        end else if (e_xs > XW'((1 << (SLW - 1)) - 1)) begin
            e_x = {1'b0, {(SLW-1){1'b1}}};
        end else begin
            e_x = e_xs[SLW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= d1_vld;
        end
        r_e_x[0]     <= e_x;
        r_e_x[1]     <= d1_sd.s;
        r_e_x[2]     <= d1_sd.e;
        r_e_sd.lin   <= d1_sd.lin;
        r_e_sd.zspan <= d1_sd.zspan;
        r_e_sd.lower <= d1_sd.lower;
        r_e_sd.dz    <= 1'b0;
        r_e_sd.neg   <= 1'b0;
        r_e_sd.lres  <= (d1_sd.sgn ^ d1_sd.lower) ? -signed'({1'b0, e_lm})
                                                  : signed'({1'b0, e_lm});
    end

    // ---------------- exponentials of x, start and end ----------------
    logic          ex_vld;
    logic [EW-1:0] ex_e [3];
    t_s2           ex_sd;

    jecm_exp #(.SW($bits(t_s2))) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_vld),
        .i_x     (r_e_x),
        .i_side  (r_e_sd),
        .o_valid (ex_vld),
        .o_e     (ex_e),
        .o_side  (ex_sd)
    );

    // ---------------- stage f: curve differences ----------------
    logic               r_f_vld;
    logic signed [EW:0] r_f_num, r_f_den;
    t_s2                r_f_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= ex_vld;
        end
        r_f_num <= signed'({1'b0, ex_e[0]}) - signed'({1'b0, ex_e[1]});
        r_f_den <= signed'({1'b0, ex_e[2]}) - signed'({1'b0, ex_e[1]});
        r_f_sd  <= ex_sd;
    end

    // ---------------- stage g: magnitudes, sign, flat curve ----------------
    logic          r_g_vld;
    logic [EW-1:0] r_g_nm, r_g_dm;
    t_s2           r_g_sd, n_g_sd;
    logic [EW:0]   g_nabs, g_dabs;

    assign g_nabs = r_f_num[EW] ? (EW+1)'(-r_f_num) : (EW+1)'(r_f_num);
    assign g_dabs = r_f_den[EW] ? (EW+1)'(-r_f_den) : (EW+1)'(r_f_den);

    always_comb begin
        n_g_sd     = r_f_sd;
        n_g_sd.dz  = r_f_den == '0;
        n_g_sd.neg = r_f_num[EW] ^ r_f_den[EW] ^ r_f_sd.lower;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
        r_g_nm <= g_nabs[EW-1:0];
        r_g_dm <= g_dabs[EW-1:0];
        r_g_sd <= n_g_sd;
    end

    // ---------------- stage h: scale by full scale ----------------
    logic           r_h_vld;
    logic [NW2-1:0] r_h_prod;
    logic [EW-1:0]  r_h_dm;
    t_s2            r_h_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
        r_h_prod <= NW2'(r_g_nm) * NW2'(FS);
        r_h_dm   <= r_g_dm;
        r_h_sd   <= r_g_sd;
    end

    // ---------------- second divide: curve ratio ----------------
    logic          d2_vld;
    logic [QW-1:0] d2_quo;
    t_s2           d2_sd;

    jecm_div #(.NW(NW2), .DW(EW), .SW($bits(t_s2))) u_div_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_vld),
        .i_num   (r_h_prod),
        .i_den   (r_h_dm),
        .i_side  (r_h_sd),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_sd)
    );

    // ---------------- output stage: select and saturate ----------------
    logic                r_o_stb;
    logic [OW-1:0]       r_o_val;
    logic [FSW-1:0]      o_cm;
    logic signed [FSW:0] o_res;

    assign o_cm = (d2_quo > QW'(FS)) ? FS : FSW'(d2_quo);

    always_comb begin
        if (d2_sd.zspan) begin
            o_res = '0;                      // half with no span
        end else if (d2_sd.lin) begin
            o_res = d2_sd.lres;              // equal slopes
        end else if (d2_sd.dz) begin
            o_res = '0;                      // flat exponential
        end else begin
            o_res = d2_sd.neg ? -signed'({1'b0, o_cm}) : signed'({1'b0, o_cm});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_stb <= 1'b0;
        end else begin
            r_o_stb <= d2_vld;
        end
        r_o_val <= o_res[OW-1:0];
    end

    assign o_strobe     = r_o_stb;
    assign o_axis_value = r_o_val;

endmodule

// File: hw/rtl/jecm_div.sv
// ---------------------------------------------------------------------------
// jecm_div: pipelined restoring divider
// unsigned quotient, one bit per stage, saturates to all ones on overflow
// ---------------------------------------------------------------------------
module jecm_div #(
    parameter int NW = 28,
    parameter int DW = 13,
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [NW-1:0]              i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [jecm_pkg::QUO_W-1:0] o_quo,
    output logic [SW-1:0]              o_side
);

    localparam int QB = jecm_pkg::QUO_W;
    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic          r_vld  [QB+1];
    logic [NW-1:0] r_rem  [QB+1];
    logic [DW-1:0] r_dn   [QB+1];
    logic [QB-1:0] r_q    [QB+1];
    logic          r_ov   [QB+1];
    logic [SW-1:0] r_side [QB+1];

    logic [CW-1:0] ov_diff;

    // quotient would not fit in QB bits
    assign ov_diff = CW'(i_num) - (CW'(i_den) << QB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= i_num;
        r_dn[0]   <= i_den;
        r_q[0]    <= '0;
        r_ov[0]   <= !ov_diff[CW-1];
        r_side[0] <= i_side;
    end

    for (genvar g = 0; g < QB; g++) begin : g_stage
        localparam int B = QB - 1 - g;
        logic [CW-1:0] diff;
        logic          ge;

        assign diff = CW'(r_rem[g]) - (CW'(r_dn[g]) << B);
        assign ge   = !diff[CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_rem[g+1]  <= ge ? diff[NW-1:0] : r_rem[g];
            r_dn[g+1]   <= r_dn[g];
            r_q[g+1]    <= {r_q[g][QB-2:0], ge};
            r_ov[g+1]   <= r_ov[g];
            r_side[g+1] <= r_side[g];
        end
    end

    assign o_valid = r_vld[QB];
    assign o_quo   = r_ov[QB] ? '1 : r_q[QB];
    assign o_side  = r_side[QB];

endmodule

// File: hw/rtl/jecm_exp.sv
// ---------------------------------------------------------------------------
// jecm_exp: three-lane exponential unit
// table lookup, split product, sum and shift over three stages
// ---------------------------------------------------------------------------
module jecm_exp #(
    parameter int SW = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [jecm_pkg::SLOPE_W-1:0] i_x [3],
    input  logic [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic [jecm_pkg::EXP_W-1:0]        o_e [3],
    output logic [SW-1:0]                     o_side
);

    localparam int PW = jecm_pkg::PTAB_W;
    localparam int FW = jecm_pkg::FTAB_W;
    localparam int FH = FW / 2;
    localparam int LW = FW - FH;
    localparam int SUM_W = PW + FW;

    logic [2:0]    r_vld;
    logic [SW-1:0] r_side [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        r_side[0] <= i_side;
        r_side[1] <= r_side[0];
        r_side[2] <= r_side[1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [jecm_pkg::SLOPE_W-1:0] u;
        logic [PW-1:0]      r_p;
        logic [FW-1:0]      r_f;
        logic [PW+FH-1:0]   r_hi;
        logic [PW+LW-1:0]   r_lo;
        logic [SUM_W-1:0]   sum;
        logic [jecm_pkg::EXP_W-1:0] r_e;

        // offset by 2048: top nibble picks the integer power
        assign u   = {~i_x[l][jecm_pkg::SLOPE_W-1], i_x[l][jecm_pkg::SLOPE_W-2:0]};
        assign sum = (SUM_W'(r_hi) << LW) + SUM_W'(r_lo);

        always_ff @(posedge i_clk) begin
            r_p  <= jecm_pkg::PTAB[u[11:8]];
            r_f  <= jecm_pkg::FTAB[u[7:0]];
            r_hi <= (PW+FH)'(r_p) * (PW+FH)'(r_f[FW-1:LW]);
            r_lo <= (PW+LW)'(r_p) * (PW+LW)'(r_f[LW-1:0]);
            r_e  <= sum[SUM_W-1:24];
        end

        assign o_e[l] = r_e;
    end

    assign o_valid = r_vld[2];
    assign o_side  = r_side[2];

endmodule

// File: hw/rtl/jecm_chk.sv
// ---------------------------------------------------------------------------
// jecm_chk: port checker of the joystick curve map
// latency, ordering and range of result words
// ---------------------------------------------------------------------------
module jecm_chk #(
    parameter int ADC_BITS       = jecm_pkg::ADC_BITS_DEF,
    parameter int OUT_FULL_SCALE = jecm_pkg::FULL_SCALE_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [ADC_BITS-1:0]               i_sample,
    input logic                              o_strobe,
    input logic signed [jecm_pkg::OUT_W-1:0] o_axis_value
);

    localparam int LAT = jecm_pkg::LATENCY;

    // every accepted word gives a result a fixed time later
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (^i_sample !== 1'bx) |-> ##LAT o_strobe)
        else $error("accepted word produced no result");

    // no result without an accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without accepted word");

    // results stay within full scale whenever full scale is at most 1023
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (OUT_FULL_SCALE > 1023) ||
                     (($signed(o_axis_value) <= OUT_FULL_SCALE) &&
                      ($signed(o_axis_value) >= -OUT_FULL_SCALE)))
        else $error("result beyond full scale");

endmodule

bind joystick_expo_curve_map_top jecm_chk #(
    .ADC_BITS       (ADC_BITS),
    .OUT_FULL_SCALE (OUT_FULL_SCALE)
) u_jecm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_sample     (i_sample),
    .o_strobe     (o_strobe),
    .o_axis_value (o_axis_value)
);

// File: tb/jecm_checker.sv
// ---------------------------------------------------------------------------
// jecm_checker: scoreboard of the joystick curve map
// shadows the calibration registers from apb writes, predicts each result
// word from the accepted adc word and compares it with the strobed output
// ---------------------------------------------------------------------------
module jecm_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic [jecm_pkg::ADC_BITS_DEF-1:0]     i_sample,
    input  logic                                  o_strobe,
    input  logic signed [jecm_pkg::OUT_W-1:0]     o_axis_value,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [jecm_pkg::ADDR_W-1:0]           paddr,
    input  logic [jecm_pkg::DATA_W-1:0]           pwdata,
    input  logic                                  pready,
    output int                                    n_fail,
    output int                                    n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [jecm_pkg::ADC_BITS_DEF-1:0]    cal_lo, cal_mid, cal_hi;
    logic signed [jecm_pkg::SLOPE_W-1:0]  slope_s, slope_e;
    logic signed [jecm_pkg::OUT_W-1:0]    axis_due [$];

    // e^(x/256 + 8) in unsigned q16, table walk done step by step
    function automatic longint unsigned expo_q16(longint x);
        longint unsigned u, k, f, p, q;
        if (x < -2048) x = -2048;
        if (x > 2047) x = 2047;
        u = longint'(x + 2048);
        k = u >> 8;
        f = u & 255;
        p = 65536;
        for (longint unsigned i = 0; i < k; i++) p = (p * jecm_pkg::EQ24) >> 24;
        q = 64'd1 << 24;
        for (longint unsigned i = 0; i < f; i++) q = (q * jecm_pkg::SQ24) >> 24;
        return (p * q) >> 24;
    endfunction

    function automatic longint shape_half(longint v, longint c, longint b, longint oend,
                                          longint s, longint e);
        longint span, x, es, ee, ex;
        span = b - c;
        if (span == 0) return 0;
        if (s == e) return ((v - c) * oend) / span;
        x = s + ((v - c) * (e - s)) / span;
        if (x < -2048) x = -2048;
        if (x > 2047) x = 2047;
        es = longint'(expo_q16(s));
        ee = longint'(expo_q16(e));
        ex = longint'(expo_q16(x));
        if (ee == es) return 0;
        return ((ex - es) * oend) / (ee - es);
    endfunction

    function automatic logic signed [jecm_pkg::OUT_W-1:0] map_axis(
        logic [jecm_pkg::ADC_BITS_DEF-1:0] smp);
        longint v, lo, mid, hi, fs, r;
        v   = smp;
        lo  = cal_lo;
        mid = cal_mid;
        hi  = cal_hi;
        fs  = jecm_pkg::FULL_SCALE_DEF;
        if (v < lo) v = lo;
        else if (v > hi) v = hi;
        if (v - mid >= 0) r = shape_half(v, mid, hi, fs, slope_s, slope_e);
        else              r = shape_half(v, mid, lo, -fs, slope_s, slope_e);
        if (r > fs) r = fs;
        if (r < -fs) r = -fs;
        return jecm_pkg::OUT_W'(r);
    endfunction

    assign n_pending = axis_due.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_lo  <= '0;
            cal_mid <= 12'd2047;
            cal_hi  <= 12'd4095;
            slope_s <= jecm_pkg::SLOPE_RESET;
            slope_e <= jecm_pkg::SLOPE_RESET;
            n_fail  <= 0;
            axis_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    jecm_pkg::REG_CAL_MIN:     cal_lo  <= pwdata[11:0];
                    jecm_pkg::REG_CAL_CENTRE:  cal_mid <= pwdata[11:0];
                    jecm_pkg::REG_CAL_MAX:     cal_hi  <= pwdata[11:0];
                    jecm_pkg::REG_SLOPE_START: slope_s <= pwdata[11:0];
                    jecm_pkg::REG_SLOPE_END:   slope_e <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (start && !busy) axis_due.push_back(map_axis(i_sample));
            if (o_strobe) begin
                if (axis_due.size() == 0) begin
                    $error("axis_value: unexpected word %0d", o_axis_value);
                    n_fail <= n_fail + 1;
                end else if (axis_due[0] !== o_axis_value) begin
                    $error("axis_value: expected %0d, got %0d", axis_due[0], o_axis_value);
                    n_fail <= n_fail + 1;
                    void'(axis_due.pop_front());
                end else begin
                    void'(axis_due.pop_front());
                end
            end
        end
    end

endmodule

// File: tb/tb_joystick_expo_curve_map_top.sv
// ---------------------------------------------------------------------------
// tb_joystick_expo_curve_map_top: testbench of the joystick curve map
// directed corner words, then randomised calibration phases with random adc
// words and random gaps; the checker predicts and compares every result word
// ---------------------------------------------------------------------------
module tb_joystick_expo_curve_map_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [jecm_pkg::ADC_BITS_DEF-1:0]    i_sample = '0;
    logic                                 o_strobe;
    logic signed [jecm_pkg::OUT_W-1:0]    o_axis_value;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [jecm_pkg::ADDR_W-1:0]          paddr = '0;
    logic [jecm_pkg::DATA_W-1:0]          pwdata = '0;
    logic [jecm_pkg::DATA_W-1:0]          prdata;
    logic                                 pready;
    int                                   n_fail;
    int                                   n_pending;

    // current calibration, kept here to aim words at the interesting points
    int                         lo_now, mid_now, hi_now;
    bit                         no_gaps;

    always #2 i_clk = ~i_clk;

    joystick_expo_curve_map_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample     (i_sample),
        .o_strobe     (o_strobe),
        .o_axis_value (o_axis_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    jecm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample     (i_sample),
        .o_strobe     (o_strobe),
        .o_axis_value (o_axis_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .n_fail       (n_fail),
        .n_pending    (n_pending)
    );

    // one adc word: driven at the falling edge, held until start && !busy
    // is seen at a rising edge (busy only moves at rising edges)
    task automatic put_word(input logic [jecm_pkg::ADC_BITS_DEF-1:0] v);
        bit taken;
        @(negedge i_clk);
        start    <= 1'b1;
        i_sample <= v;
        taken = 1'b0;
        while (!taken) begin
            if (!busy) begin
                taken = 1'b1;
                @(posedge i_clk);
            end else begin
                @(negedge i_clk);
            end
        end
    endtask

    // sender goes quiet, with a random word on the bus
    task automatic go_quiet(input int n);
        @(negedge i_clk);
        start    <= 1'b0;
        i_sample <= jecm_pkg::ADC_BITS_DEF'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // random gap in about 12 of a hundred words, unless in the quiet-free stretch
    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(99) < 12) go_quiet($urandom_range(1, 6));
    endtask

    // wait for every word to come back, then let the pipe settle
    task automatic drain();
        go_quiet(1);
        while (n_pending != 0) @(negedge i_clk);
        repeat (jecm_pkg::LATENCY + 4) @(negedge i_clk);
    endtask

    // apb write: setup cycle then access cycle, pready is tied high
    task automatic reg_write(input logic [2:0] idx,
                             input logic [jecm_pkg::DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // whole calibration set, only ever called with the block drained
    task automatic set_cal(input int lo, input int mid, input int hi,
                           input int s, input int e);
        reg_write(jecm_pkg::REG_CAL_MIN, jecm_pkg::DATA_W'(lo));
        reg_write(jecm_pkg::REG_CAL_CENTRE, jecm_pkg::DATA_W'(mid));
        reg_write(jecm_pkg::REG_CAL_MAX, jecm_pkg::DATA_W'(hi));
        reg_write(jecm_pkg::REG_SLOPE_START, jecm_pkg::DATA_W'(s));
        reg_write(jecm_pkg::REG_SLOPE_END, jecm_pkg::DATA_W'(e));
        lo_now  = lo;
        mid_now = mid;
        hi_now  = hi;
    endtask

    // word near one of the calibration points, or anywhere
    function automatic logic [jecm_pkg::ADC_BITS_DEF-1:0] pick_word();
        int base, w;
        case ($urandom_range(9))
            0, 1:    base = lo_now;
            2, 3, 4: base = mid_now;
            5, 6:    base = hi_now;
            default: return jecm_pkg::ADC_BITS_DEF'($urandom);
        endcase
        w = base + $urandom_range(40) - 20;
        if (w < 0) w = 0;
        if (w > 4095) w = 4095;
        return jecm_pkg::ADC_BITS_DEF'(w);
    endfunction

    function automatic int rand_slope();
        case ($urandom_range(5))
            0:       return -2048;
            1:       return 2047;
            default: return $urandom_range(4095) - 2048;
        endcase
    endfunction

    initial begin
        int lo, mid, hi, s, e;
        lo_now  = 0;
        mid_now = 2047;
        hi_now  = 4095;
        no_gaps = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: both ends, centre and its neighbours, bit patterns
        put_word(12'd0);
        put_word(12'd4095);
        put_word(12'd2047);
        put_word(12'd2046);
        put_word(12'd2048);
        put_word(12'hAAA);
        put_word(12'h555);
        drain();

        // steepest rising and falling curves over the full range
        set_cal(0, 2047, 4095, -2048, 2047);
        put_word(12'd0); put_word(12'd1); put_word(12'd2047);
        put_word(12'd3000); put_word(12'd4095);
        drain();
        set_cal(0, 2047, 4095, 2047, -2048);
        put_word(12'd0); put_word(12'd1000); put_word(12'd4094); put_word(12'd4095);
        drain();

        // equal slopes give the linear map; adjacent slopes nearly flat
        set_cal(100, 2000, 3900, -300, -300);
        put_word(12'd0); put_word(12'd100); put_word(12'd2999); put_word(12'd4095);
        drain();
        set_cal(100, 2000, 3900, -2048, -2047);
        put_word(12'd50); put_word(12'd1999); put_word(12'd3000);
        drain();

        // zero span on the upper half, then inverted calibration
        set_cal(500, 3000, 3000, 256, 1024);
        put_word(12'd4095); put_word(12'd3000); put_word(12'd1000);
        drain();
        set_cal(3500, 4000, 600, 512, -512);
        put_word(12'd0); put_word(12'd4095); put_word(12'd2000);
        drain();

        // random phases: about 1420 words over ten calibrations
        for (int ph = 0; ph < 10; ph++) begin
            lo  = $urandom_range(1500);
            hi  = $urandom_range(4095, 2500);
            mid = $urandom_range(hi, lo);
            s   = rand_slope();
            e   = rand_slope();
            case (ph)
                0: begin lo = 0; hi = 4095; end
                3: e = s;
                5: mid = hi;
                6: mid = lo;
                7: begin lo = $urandom_range(4095, 2500); hi = $urandom_range(1500); end
                8: mid = $urandom_range(4095);
                default: ;
            endcase
            set_cal(lo, mid, hi, s, e);
            for (int n = 0; n < 142; n++) begin
                // a long stretch with no gaps at all in the middle phase
                no_gaps = (ph == 4);
                // at least once the sender waits for every word to come back
                if (ph == 2 && n == 70) while (n_pending != 0) go_quiet(1);
                maybe_gap();
                put_word(pick_word());
            end
            drain();
        end

        // verdict from the failure count and the words still pending
        if (n_fail == 0 && n_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
